>>> src/next_two_primes_finder_top_assert.svh
// Assertion macros for the next-two-primes finder.
`ifndef NEXT_TWO_PRIMES_FINDER_TOP_ASSERT_SVH
`define NEXT_TWO_PRIMES_FINDER_TOP_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define NTPF_ASSERT_NOW(label, cond_a, cond_b) \
  label: assert property (@(posedge clk) disable iff (rst) (cond_a) |-> (cond_b)) \
    else $error("ntpf check failed: same-cycle rule");

// Next-cycle implication.
`define NTPF_ASSERT_NEXT(label, cond_a, cond_b) \
  label: assert property (@(posedge clk) disable iff (rst) (cond_a) |=> (cond_b)) \
    else $error("ntpf check failed: next-cycle rule");

`endif

>>> src/ntpf_pkg.sv
package ntpf_pkg;

  localparam int VALUE_BITS     = 16;
  localparam int OUT_BITS       = VALUE_BITS + 1;
  // trial divisors stay near sqrt of the candidate
  localparam int DIV_BITS       = OUT_BITS / 2 + 2;
  localparam int SQ_BITS        = OUT_BITS + 1;
  localparam int CNT_BITS       = $clog2(OUT_BITS + 1);
  localparam int IN_TDATA_BITS  = ((VALUE_BITS + 7) / 8) * 8;
  localparam int OUT_TDATA_BITS = ((2 * OUT_BITS + 7) / 8) * 8;

  typedef struct packed {
    logic                start;
    logic [OUT_BITS-1:0] dividend;
    logic [DIV_BITS-1:0] divisor;
  } mod_req_t;

  typedef struct packed {
    logic done;
    logic rem_zero;
  } mod_stat_t;

endpackage

>>> src/next_two_primes_finder_top.sv
// Next-two-primes finder. Each transaction on the slave side carries a 16-bit
// unsigned start value; the block answers with one master-side transaction
// holding the smallest prime above the start value and the prime after it
// (0 and 1 both give 2 and 3; 65535 gives 65537 and 65539). Candidates are
// tested upward by trial division: even candidates other than 2 are dropped
// by the classify cycle, odd ones are divided by 3, 5, 7, ... while the
// divisor squared does not exceed the candidate. All divisions run on one
// shared bit-serial remainder unit: a start, one shift per dividend bit and
// a wait state that acts on the done flag make up each divisor tried.
// Every candidate is stepped and classified, an odd candidate adds one such
// division per divisor tried, and an odd prime adds a final square check and
// capture. An item ends by handing the pair to the output register.
// s_tready is high only while the sequencer is idle; the finished result sits
// in an output register, so the next start value is taken while the previous
// result waits for m_tready.
module next_two_primes_finder_top
  import ntpf_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [IN_TDATA_BITS-1:0]  s_tdata,   // [15:0] start_value
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [OUT_TDATA_BITS-1:0] m_tdata    // [16:0] first_prime,
                                               // [33:17] second_prime, rest 0
);

  logic                res_valid;
  logic                res_ready;
  logic [OUT_BITS-1:0] first_prime;
  logic [OUT_BITS-1:0] second_prime;
  logic [OUT_BITS-1:0] first_q;
  logic [OUT_BITS-1:0] second_q;
  mod_req_t            mod_req;
  mod_stat_t           mod_stat;

  ntpf_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (s_tvalid),
    .in_ready     (s_tready),
    .start_value  (s_tdata[VALUE_BITS-1:0]),
    .res_valid    (res_valid),
    .res_ready    (res_ready),
    .first_prime  (first_prime),
    .second_prime (second_prime),
    .mod_req      (mod_req),
    .mod_stat     (mod_stat)
  );

  ntpf_mod u_mod (
    .clk  (clk),
    .rst  (rst),
    .req  (mod_req),
    .stat (mod_stat)
  );

  // output register: loads when empty or being drained this cycle
  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else begin
      if (res_ready) begin
        m_tvalid <= res_valid;
      end
      if (res_valid && res_ready) begin
        first_q  <= first_prime;
        second_q <= second_prime;
      end
    end
  end

  assign m_tdata = OUT_TDATA_BITS'({second_q, first_q});

endmodule

>>> src/ntpf_mod.sv
// Bit-serial restoring remainder: one dividend bit per cycle.
module ntpf_mod
  import ntpf_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  mod_req_t  req,
  output mod_stat_t stat
);

  logic [OUT_BITS-1:0] dvd;
  logic [DIV_BITS-1:0] dsr;
  logic [DIV_BITS-1:0] rem;
  logic [CNT_BITS-1:0] cnt;
  logic                busy;
  logic                done;
  logic [DIV_BITS:0]   trial;
  logic [DIV_BITS:0]   diff;

  assign trial = {rem, dvd[OUT_BITS-1]};
  assign diff  = trial - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        dvd  <= req.dividend;
        dsr  <= req.divisor;
        rem  <= '0;
        cnt  <= CNT_BITS'(OUT_BITS);
        busy <= 1'b1;
      end else if (busy) begin
        dvd <= {dvd[OUT_BITS-2:0], 1'b0};
        if (trial >= {1'b0, dsr}) begin
          rem <= diff[DIV_BITS-1:0];
        end else begin
          rem <= trial[DIV_BITS-1:0];
        end
        cnt <= cnt - 1'b1;
        if (cnt == CNT_BITS'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign stat.done     = done;
  assign stat.rem_zero = (rem == '0);

endmodule

>>> src/ntpf_ctrl.sv
// Candidate sequencer: steps candidates upward and drives trial divisions.
module ntpf_ctrl
  import ntpf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [VALUE_BITS-1:0] start_value,
  output logic                  res_valid,
  input  logic                  res_ready,
  output logic [OUT_BITS-1:0]   first_prime,
  output logic [OUT_BITS-1:0]   second_prime,
  output mod_req_t              mod_req,
  input  mod_stat_t             mod_stat
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_NEXT  = 3'd1;
  localparam logic [2:0] ST_CLASS = 3'd2;
  localparam logic [2:0] ST_TRIAL = 3'd3;
  localparam logic [2:0] ST_WAIT  = 3'd4;
  localparam logic [2:0] ST_PRIME = 3'd5;
  localparam logic [2:0] ST_DONE  = 3'd6;

  logic [2:0]          state;
  logic                found;
  logic [OUT_BITS-1:0] cand;
  logic [DIV_BITS-1:0] dsr;
  logic [SQ_BITS-1:0]  sq;
  logic                sq_over;

  assign sq_over = (sq > {1'b0, cand});

  assign in_ready         = (state == ST_IDLE);
  assign res_valid        = (state == ST_DONE);
  assign mod_req.start    = (state == ST_TRIAL) && !sq_over;
  assign mod_req.dividend = cand;
  assign mod_req.divisor  = dsr;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      found <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            cand  <= {1'b0, start_value};
            found <= 1'b0;
            state <= ST_NEXT;
          end
        end
        ST_NEXT: begin
          cand  <= cand + 1'b1;
          state <= ST_CLASS;
        end
        ST_CLASS: begin
          // below two, or even and not two: rejected at once
          if (cand < OUT_BITS'(2)) begin
            state <= ST_NEXT;
          end else if (!cand[0]) begin
            state <= (cand == OUT_BITS'(2)) ? ST_PRIME : ST_NEXT;
          end else begin
            dsr   <= DIV_BITS'(3);
            sq    <= SQ_BITS'(9);
            state <= ST_TRIAL;
          end
        end
        ST_TRIAL: begin
          state <= sq_over ? ST_PRIME : ST_WAIT;
        end
        ST_WAIT: begin
          if (mod_stat.done) begin
            if (mod_stat.rem_zero) begin
              state <= ST_NEXT;
            end else begin
              // (d+2)^2 = d^2 + 4d + 4
              sq    <= sq + SQ_BITS'({dsr, 2'b00}) + SQ_BITS'(4);
              dsr   <= dsr + DIV_BITS'(2);
              state <= ST_TRIAL;
            end
          end
        end
        ST_PRIME: begin
          if (!found) begin
            first_prime <= cand;
            found       <= 1'b1;
            state       <= ST_NEXT;
          end else begin
            second_prime <= cand;
            state        <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (res_ready) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

>>> src/ntpf_checker.sv
`include "next_two_primes_finder_top_assert.svh"

module ntpf_checker
  import ntpf_pkg::*;
(
  input logic                      clk,
  input logic                      rst,
  input logic                      s_tvalid,
  input logic                      s_tready,
  input logic [IN_TDATA_BITS-1:0]  s_tdata,
  input logic                      m_tvalid,
  input logic                      m_tready,
  input logic [OUT_TDATA_BITS-1:0] m_tdata
);

  logic [OUT_BITS-1:0] p1;
  logic [OUT_BITS-1:0] p2;

  assign p1 = m_tdata[OUT_BITS-1:0];
  assign p2 = m_tdata[2*OUT_BITS-1:OUT_BITS];

  `NTPF_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
  `NTPF_ASSERT_NOW(a_order, m_tvalid, p2 > p1)
  `NTPF_ASSERT_NOW(a_floor, m_tvalid, p1 >= OUT_BITS'(2))
  `NTPF_ASSERT_NOW(a_pad_zero, m_tvalid, m_tdata[OUT_TDATA_BITS-1:2*OUT_BITS] == '0)
  `NTPF_ASSERT_NEXT(a_busy_after_take, s_tvalid && s_tready, !s_tready)

endmodule

bind next_two_primes_finder_top ntpf_checker u_checker (.*);

>>> dv/next_two_primes_finder_top_tb.sv
// Self-checking bench for the next-two-primes finder.
// A driver process feeds start values from a queue onto the slave stream;
// each accepted transaction is run through a local trial-division predictor,
// and the pair of primes it yields is queued. A monitor process compares each
// master-side transaction against the oldest queued pair, field by field.
module next_two_primes_finder_top_tb
  import ntpf_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // One predicted result: both primes at the block's output width.
  typedef struct packed {
    logic [OUT_BITS-1:0] upper_prime;
    logic [OUT_BITS-1:0] lower_prime;
  } prime_pair_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      s_tvalid = 1'b0;
  logic                      s_tready;
  logic [IN_TDATA_BITS-1:0]  s_tdata = '0;
  logic                      m_tvalid;
  logic                      m_tready = 1'b0;
  logic [OUT_TDATA_BITS-1:0] m_tdata;

  // Start values waiting to be offered, and prime pairs waiting to come out.
  logic [VALUE_BITS-1:0] start_q[$];
  prime_pair_t           prime_pair_q[$];

  // Knobs set by the sequencing block, always at the falling edge.
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  bit          long_stall    = 1'b0;

  int unsigned err_count        = 0;
  int unsigned start_count      = 0;
  int unsigned pair_count       = 0;
  int unsigned input_stall_cyc  = 0;

  next_two_primes_finder_top DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Predictor: plain trial division, odd divisors only, 0 and 1 not prime.
  // ---------------------------------------------------------------------
  function automatic bit is_prime_val(int unsigned n);
    int unsigned d;
    if (n < 2) return 1'b0;
    if (n[0] == 1'b0) return n == 2;
    for (d = 3; d * d <= n; d += 2)
      if (n % d == 0) return 1'b0;
    return 1'b1;
  endfunction

  function automatic int unsigned prime_after(int unsigned v);
    int unsigned c;
    c = v + 1;
    while (!is_prime_val(c)) c++;
    return c;
  endfunction

  function automatic prime_pair_t predict_primes(logic [VALUE_BITS-1:0] start);
    prime_pair_t pp;
    int unsigned p1;
    int unsigned p2;
    p1 = prime_after(32'(start));
    p2 = prime_after(p1);
    pp.lower_prime = p1[OUT_BITS-1:0];
    pp.upper_prime = p2[OUT_BITS-1:0];
    return pp;
  endfunction

  task automatic report_mismatch(string msg);
    err_count++;
    $display("[%0t] MISMATCH: %s", $realtime, msg);
  endtask

  // ---------------------------------------------------------------------
  // Driver: one NBA per signal per edge. A held item stays up until the
  // handshake; after a transaction the next item (if any) goes up unless the idle draw holds it off.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin : drive_starts
    bit fire;
    fire = s_tvalid && s_tready;
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata  <= '0;
    end else begin
      if (fire) begin
        prime_pair_q.push_back(predict_primes(s_tdata[VALUE_BITS-1:0]));
        start_count++;
      end
      if (s_tvalid && !s_tready)
        input_stall_cyc++;
      if (s_tvalid && !fire) begin
        // hold current transaction
      end else if (start_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        s_tvalid <= 1'b1;
        s_tdata  <= start_q.pop_front();
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: check every master-side transaction, then pick next m_tready.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin : check_primes
    prime_pair_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        pair_count++;
        if (prime_pair_q.size() == 0) begin
          report_mismatch($sformatf("result %h with nothing pending", m_tdata));
        end else begin
          want = prime_pair_q.pop_front();
          if (m_tdata[OUT_BITS-1:0] !== want.lower_prime)
            report_mismatch($sformatf("first_prime got %0d want %0d",
                                      m_tdata[OUT_BITS-1:0], want.lower_prime));
          if (m_tdata[2*OUT_BITS-1:OUT_BITS] !== want.upper_prime)
            report_mismatch($sformatf("second_prime got %0d want %0d",
                                      m_tdata[2*OUT_BITS-1:OUT_BITS], want.upper_prime));
          // pad bits above the two fields must read zero
          if (m_tdata[OUT_TDATA_BITS-1:2*OUT_BITS] !== '0)
            report_mismatch($sformatf("pad bits got %h",
                                      m_tdata[OUT_TDATA_BITS-1:2*OUT_BITS]));
        end
      end
      m_tready <= !long_stall && ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Random start value: half full range, the rest weighted to the fast low
  // end and to the top of the range, near where results need the 17th bit.
  function automatic logic [VALUE_BITS-1:0] rand_start();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50)      return VALUE_BITS'($urandom_range(0, 65535));
    else if (r < 75) return VALUE_BITS'($urandom_range(0, 255));
    else             return VALUE_BITS'($urandom_range(65000, 65535));
  endfunction

  // Sender pauses here until every queued item went in and came back out.
  task automatic wait_drained();
    do @(negedge clk);
    while (start_q.size() != 0 || s_tvalid || prime_pair_q.size() != 0);
  endtask

  task automatic run_random(int unsigned n, int unsigned s_pct, int unsigned r_pct);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    repeat (n) start_q.push_back(rand_start());
    wait_drained();
  endtask

  // ---------------------------------------------------------------------
  // Sequencing
  // ---------------------------------------------------------------------
  initial begin : run_phases
    logic [VALUE_BITS-1:0] directed[$];
    rst = 1'b1;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: zero and one (1 is not prime), smallest primes, twins,
    // the largest 16-bit prime and all ones (results need 17 bits),
    // alternating bit patterns, and starts inside wide prime gaps.
    directed = '{16'd0, 16'd1, 16'd2, 16'd3, 16'd4, 16'd5, 16'd7, 16'd10,
                 16'd11, 16'd29, 16'd1327, 16'd31397, 16'd31400, 16'd32767,
                 16'h5555, 16'hAAAA, 16'd65519, 16'd65520, 16'd65521,
                 16'd65534, 16'hFFFF};
    send_idle_pct = 0;
    recv_idle_pct = 0;
    foreach (directed[i]) start_q.push_back(directed[i]);
    wait_drained();

    // Random phases: no idling, sender idle, receiver stalling, both.
    run_random(30, 0, 0);
    run_random(30, 66, 0);
    run_random(30, 0, 66);
    run_random(30, 23, 23);

    // Backpressure: receiver holds off while small (fast) starts keep
    // coming, so the output register fills and s_tready drops.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (6) start_q.push_back(VALUE_BITS'($urandom_range(0, 200)));
    long_stall = 1'b1;
    repeat (3000) @(negedge clk);
    long_stall = 1'b0;
    wait_drained();

    // Trailing window: catch any stray result after the last one.
    repeat (200) @(negedge clk);
    if (prime_pair_q.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", prime_pair_q.size()));

    $display("Covered %0d start values, %0d results, %0d cycles of input backpressure.",
             start_count, pair_count, input_stall_cyc);
    $display("Phases: directed edges, free-running, sender idle, receiver stall, mixed.");
    if (err_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog: far above the slowest legal run of all items.
  initial begin : watchdog
    #(100_000_000);
    $display("FAILURE");
    $finish;
  end

endmodule

>>> next_two_primes_finder_top.f
+incdir+src
src/ntpf_pkg.sv
src/ntpf_mod.sv
src/ntpf_ctrl.sv
src/next_two_primes_finder_top.sv
src/ntpf_checker.sv
dv/next_two_primes_finder_top_tb.sv
